// ----- rtl/vtcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtcs_pkg: shared types and constants of the terrain column span generator
// Operation codes, register indexes, queue entry and configuration structs.
// ----------------------------------------------------------------------------
package vtcs_pkg;

    localparam int MAP_AW    = 20;          // log2 of map texels
    localparam int COL_W     = 11;          // log2 of screen columns
    localparam int QDEPTH    = 4;           // front to back queue depth
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int DIV_STEPS = 17;          // quotient bits before saturation
    localparam int NUM_W     = 35;          // projection numerator
    localparam int REM_W     = 37;          // remainder and shifted divisor
    localparam int OCC_W     = 16;          // stored occlusion row

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_FRAME  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_CAMERA  = 2'd0,
        REG_HORIZON = 2'd1,
        REG_SCREEN  = 2'd2,
        REG_SHIFT   = 2'd3
    } t_reg;

    typedef struct packed {
        logic [17:0]        camera_height;
        logic signed [12:0] horizon_row;
        logic [11:0]        screen_height;
        logic [3:0]         map_shift;
    } t_cfg;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic              frame;
        logic [COL_W-1:0]  column;
        logic [19:0]       depth;
        logic [7:0]        altitude;
        logic [31:0]       color;
    } t_item;

endpackage
`default_nettype wire

// ----- rtl/voxel_terrain_column_spans.sv -----
// Throughput: one item per cycle while the output is not stalled and no clearing pass runs; the divider has 17 stages.
// A frame start holds the back pipeline for an occlusion clearing pass over all columns.
// After reset the same clearing pass runs before the first span.
// Reset is synchronous and active low; control registers take their reset values.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_terrain_column_spans: voxel terrain span generator
// Configuration registers, intake front, item queue and span back end.
// ----------------------------------------------------------------------------
module voxel_terrain_column_spans (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [17:0]         i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_operation,
    input  wire  [19:0]         i_map_address,
    input  wire  [7:0]          i_texel_altitude,
    input  wire  [31:0]         i_texel_color,
    input  wire  [10:0]         i_screen_column,
    input  wire  signed [23:0]  i_sample_x,
    input  wire  signed [23:0]  i_sample_y,
    input  wire  [19:0]         i_sample_depth,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_span_valid,
    output logic [10:0]         o_span_column,
    output logic [11:0]         o_span_top,
    output logic [11:0]         o_span_bottom,
    output logic [31:0]         o_span_color
);

    vtcs_pkg::t_cfg                  r_cfg;
    vtcs_pkg::t_item                 push_item, head_item;
    logic                            push, pop, head_v;
    logic [vtcs_pkg::QCNT_W-1:0]     q_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_height <= 18'd45568;
            r_cfg.horizon_row   <= 13'sd0;
            r_cfg.screen_height <= 12'd480;
            r_cfg.map_shift     <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vtcs_pkg::REG_CAMERA:  r_cfg.camera_height <= i_cfg_data;
                vtcs_pkg::REG_HORIZON: r_cfg.horizon_row   <= $signed(i_cfg_data[12:0]);
                vtcs_pkg::REG_SCREEN:  r_cfg.screen_height <= i_cfg_data[11:0];
                vtcs_pkg::REG_SHIFT:   r_cfg.map_shift     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    vtcs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_map_address    (i_map_address),
        .i_texel_altitude (i_texel_altitude),
        .i_texel_color    (i_texel_color),
        .i_screen_column  (i_screen_column),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_sample_depth   (i_sample_depth),
        .i_q_count        (q_count),
        .o_push           (push),
        .o_item           (push_item)
    );

    vtcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_valid (head_v),
        .o_data  (head_item),
        .o_count (q_count)
    );

    vtcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (head_v),
        .i_q_item      (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_span_valid  (o_span_valid),
        .o_span_column (o_span_column),
        .o_span_top    (o_span_top),
        .o_span_bottom (o_span_bottom),
        .o_span_color  (o_span_color)
    );

endmodule
`default_nettype wire

// ----- rtl/vtcs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtcs_queue: short item queue between front and back
// Small register queue with a fill count; head is read without delay.
// ----------------------------------------------------------------------------
module vtcs_queue (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  vtcs_pkg::t_item            i_data,
    input  wire                        i_pop,
    output logic                       o_valid,
    output vtcs_pkg::t_item            o_data,
    output logic [vtcs_pkg::QCNT_W-1:0] o_count
);

    vtcs_pkg::t_item                    r_mem [vtcs_pkg::QDEPTH];
    logic [vtcs_pkg::QPTR_W-1:0]        r_wr, r_rd;
    logic [vtcs_pkg::QCNT_W-1:0]        r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vtcs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtcs_front: item intake and map access
// Accepts items, writes texels of load items, looks up the texel of each
// sample and hands samples and frame starts on to the queue.
// ----------------------------------------------------------------------------
module vtcs_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  vtcs_pkg::t_cfg              i_cfg,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [1:0]                  i_operation,
    input  wire  [19:0]                 i_map_address,
    input  wire  [7:0]                  i_texel_altitude,
    input  wire  [31:0]                 i_texel_color,
    input  wire  [10:0]                 i_screen_column,
    input  wire  signed [23:0]          i_sample_x,
    input  wire  signed [23:0]          i_sample_y,
    input  wire  [19:0]                 i_sample_depth,
    input  wire  [vtcs_pkg::QCNT_W-1:0] i_q_count,
    output logic                        o_push,
    output vtcs_pkg::t_item             o_item
);

    localparam int MAP_TEXELS = 2 ** vtcs_pkg::MAP_AW;

    logic [7:0]                  r_alt_mem [MAP_TEXELS];
    logic [31:0]                 r_col_mem [MAP_TEXELS];

    logic                        r_s1_v;
    logic                        r_s1_frame;
    logic [vtcs_pkg::COL_W-1:0]  r_s1_col;
    logic [19:0]                 r_s1_depth;
    logic [7:0]                  r_alt;
    logic [31:0]                 r_color;

    logic                        accept;
    logic                        is_load, is_sample, is_frame;
    logic signed [15:0]          ix, iy;
    logic [15:0]                 mask;
    logic [15:0]                 mx, my;
    logic [35:0]                 row_off;
    logic [vtcs_pkg::MAP_AW-1:0] rd_addr;

    // Room is kept for the item already in flight.
    assign o_in_stall = ({1'b0, i_q_count} + {3'b0, r_s1_v})
                        >= (vtcs_pkg::QCNT_W+1)'(vtcs_pkg::QDEPTH);
    assign accept     = i_in_valid && !o_in_stall;
    assign is_load    = (i_operation == vtcs_pkg::OP_LOAD);
    assign is_sample  = (i_operation == vtcs_pkg::OP_SAMPLE);
    assign is_frame   = (i_operation == vtcs_pkg::OP_FRAME);

    // Integer parts truncate toward zero, then wrap by the map side.
    always_comb begin
        ix = i_sample_x[23:8] + 16'(i_sample_x[23] && (i_sample_x[7:0] != 8'd0));
        iy = i_sample_y[23:8] + 16'(i_sample_y[23] && (i_sample_y[7:0] != 8'd0));
        mask    = 16'((17'd1 << i_cfg.map_shift) - 17'd1);
        mx      = ix & mask;
        my      = iy & mask;
        row_off = {20'd0, my} << i_cfg.map_shift;
        rd_addr = row_off[vtcs_pkg::MAP_AW-1:0] + {4'd0, mx};
    end

    // Texel maps: one write or one registered read per item.
    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_alt_mem[i_map_address] <= i_texel_altitude;
            r_col_mem[i_map_address] <= i_texel_color;
        end
        if (accept && is_sample) begin
            r_alt   <= r_alt_mem[rd_addr];
            r_color <= r_col_mem[rd_addr];
        end
    end

    // Item fields that travel beside the map read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_frame <= is_frame;
            r_s1_col   <= i_screen_column;
            r_s1_depth <= i_sample_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept && (is_sample || is_frame);
        end
    end

    assign o_push          = r_s1_v;
    assign o_item.frame    = r_s1_frame;
    assign o_item.column   = r_s1_col;
    assign o_item.depth    = r_s1_depth;
    assign o_item.altitude = r_alt;
    assign o_item.color    = r_color;

endmodule
`default_nettype wire

// ----- rtl/vtcs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtcs_back: projection, division and column occlusion
// Pipelined restoring divider for the projected top, then a read, compare
// and write of the per-column occlusion buffer, then the span register.
// ----------------------------------------------------------------------------
module vtcs_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  vtcs_pkg::t_cfg       i_cfg,
    input  wire                  i_q_valid,
    input  vtcs_pkg::t_item      i_q_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_span_valid,
    output logic [10:0]          o_span_column,
    output logic [11:0]          o_span_top,
    output logic [11:0]          o_span_bottom,
    output logic [31:0]          o_span_color
);

    localparam int NSTG    = vtcs_pkg::DIV_STEPS;
    localparam int COLS    = 2 ** vtcs_pkg::COL_W;
    localparam int OW      = vtcs_pkg::OCC_W;

    typedef struct packed {
        logic                          v;
        logic                          frame;
        logic                          neg;
        logic                          ovf;
        logic [vtcs_pkg::REM_W-1:0]    rem;
        logic [NSTG-1:0]               q;
        logic [19:0]                   d;
        logic [vtcs_pkg::COL_W-1:0]    col;
        logic [31:0]                   color;
    } t_div;

    // Occlusion buffer: touched flag over the stored row.
    logic [OW:0]                     r_occ_mem [COLS];
    logic [OW:0]                     r_occ_q;

    logic                            en;
    logic                            r_clr_busy, r_clr_done;
    logic [vtcs_pkg::COL_W-1:0]      r_clr_cnt;

    // Numerator stage.
    logic                            r_h_v, r_h_frame;
    logic signed [vtcs_pkg::NUM_W-1:0] r_h_num;
    logic [19:0]                     r_h_d;
    logic [vtcs_pkg::COL_W-1:0]      r_h_col;
    logic [31:0]                     r_h_color;

    t_div                            r_dv [NSTG+1];

    // Saturated top stage.
    logic                            r_t_v, r_t_frame;
    logic signed [OW-1:0]            r_t_top;
    logic [vtcs_pkg::COL_W-1:0]      r_t_col;
    logic [31:0]                     r_t_color;

    // Occlusion read stage.
    logic                            r_r_v, r_r_frame;
    logic signed [OW-1:0]            r_r_top;
    logic [vtcs_pkg::COL_W-1:0]      r_r_col;
    logic [31:0]                     r_r_color;

    // Last occlusion write, for the item right behind it.
    logic                            r_fwd_v;
    logic [vtcs_pkg::COL_W-1:0]      r_fwd_col;
    logic signed [OW-1:0]            r_fwd_val;

    logic                            r_out_v;

    logic [19:0]                     dq;
    logic signed [19:0]              diff;
    logic signed [20:0]              d_s;
    logic signed [33:0]              hprod;
    logic signed [vtcs_pkg::NUM_W-1:0] num;
    logic [vtcs_pkg::NUM_W-1:0]      mag;
    logic [vtcs_pkg::REM_W-1:0]      dshift;

    logic signed [OW-1:0]            sat_top;
    logic                            fwd_hit;
    logic                            touched;
    logic signed [OW:0]              bottom, top_c, top_x;
    logic                            span_ok;
    logic signed [OW-1:0]            new_occ;

    // Whole back pipeline moves together.
    assign en    = !(r_out_v && i_out_stall) && !r_clr_busy
                   && !(r_r_v && r_r_frame && !r_clr_done);
    assign o_pop = en && i_q_valid;

    // Projection numerator: diff * 240 + horizon * depth.
    always_comb begin
        dq    = (i_q_item.depth == 20'd0) ? 20'd1 : i_q_item.depth;
        diff  = $signed({2'b00, i_cfg.camera_height})
                - $signed({4'b0000, i_q_item.altitude, 8'h00});
        d_s   = $signed({1'b0, dq});
        hprod = i_cfg.horizon_row * d_s;
        num   = (vtcs_pkg::NUM_W'(diff) <<< 8) - (vtcs_pkg::NUM_W'(diff) <<< 4)
                + vtcs_pkg::NUM_W'(hprod);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_num   <= num;
            r_h_d     <= dq;
            r_h_frame <= i_q_item.frame;
            r_h_col   <= i_q_item.column;
            r_h_color <= i_q_item.color;
        end
    end

    // Divider entry: magnitude and overflow of the quotient range.
    always_comb begin
        mag    = r_h_num[vtcs_pkg::NUM_W-1] ? vtcs_pkg::NUM_W'(-r_h_num)
                                            : vtcs_pkg::NUM_W'(r_h_num);
        dshift = {{(vtcs_pkg::REM_W-20){1'b0}}, r_h_d} << NSTG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].v <= 1'b0;
        end else if (en) begin
            r_dv[0].v     <= r_h_v;
            r_dv[0].frame <= r_h_frame;
            r_dv[0].neg   <= r_h_num[vtcs_pkg::NUM_W-1];
            r_dv[0].ovf   <= {2'b00, mag} >= dshift;
            r_dv[0].rem   <= {2'b00, mag};
            r_dv[0].q     <= '0;
            r_dv[0].d     <= r_h_d;
            r_dv[0].col   <= r_h_col;
            r_dv[0].color <= r_h_color;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= NSTG; k++) begin : g_div
        logic [vtcs_pkg::REM_W-1:0] dk;
        logic                       ge;
        always_comb begin
            dk = {{(vtcs_pkg::REM_W-20){1'b0}}, r_dv[k-1].d} << (NSTG - k);
            ge = r_dv[k-1].rem >= dk;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].v <= 1'b0;
            end else if (en) begin
                r_dv[k].v     <= r_dv[k-1].v;
                r_dv[k].frame <= r_dv[k-1].frame;
                r_dv[k].neg   <= r_dv[k-1].neg;
                r_dv[k].ovf   <= r_dv[k-1].ovf;
                r_dv[k].rem   <= ge ? (r_dv[k-1].rem - dk) : r_dv[k-1].rem;
                r_dv[k].q     <= r_dv[k-1].q | (NSTG'(ge) << (NSTG - k));
                r_dv[k].d     <= r_dv[k-1].d;
                r_dv[k].col   <= r_dv[k-1].col;
                r_dv[k].color <= r_dv[k-1].color;
            end
        end
    end

    // Sign and saturation of the quotient.
    always_comb begin
        if (r_dv[NSTG].neg) begin
            if (r_dv[NSTG].ovf || (r_dv[NSTG].q > 17'd32768)) begin
                sat_top = 16'sh8000;
            end else begin
                sat_top = OW'(-$signed({1'b0, r_dv[NSTG].q}));
            end
        end else begin
            if (r_dv[NSTG].ovf || (r_dv[NSTG].q > 17'd32767)) begin
                sat_top = 16'sh7FFF;
            end else begin
                sat_top = OW'(r_dv[NSTG].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_top   <= sat_top;
            r_t_frame <= r_dv[NSTG].frame;
            r_t_col   <= r_dv[NSTG].col;
            r_t_color <= r_dv[NSTG].color;
            r_r_top   <= r_t_top;
            r_r_frame <= r_t_frame;
            r_r_col   <= r_t_col;
            r_r_color <= r_t_color;
        end
    end

    // Valid bits of the numerator, top and read stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
            r_t_v <= 1'b0;
            r_r_v <= 1'b0;
        end else if (en) begin
            r_h_v <= o_pop;
            r_t_v <= r_dv[NSTG].v;
            r_r_v <= r_t_v;
        end
    end

    // Bottom row, span decision and next occlusion row.
    always_comb begin
        fwd_hit = r_fwd_v && (r_fwd_col == r_r_col);
        touched = fwd_hit ? 1'b1 : r_occ_q[OW];
        if (!touched) begin
            bottom = $signed({5'd0, i_cfg.screen_height});
        end else if (fwd_hit) begin
            bottom = (OW+1)'(r_fwd_val);
        end else begin
            bottom = (OW+1)'($signed(r_occ_q[OW-1:0]));
        end
        top_x   = (OW+1)'(r_r_top);
        top_c   = r_r_top[OW-1] ? '0 : top_x;
        span_ok = top_c <= bottom;
        new_occ = (top_x < bottom) ? r_r_top : OW'(bottom);
    end

    // Occlusion buffer: registered read, one write port for update or clear.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_occ_q <= r_occ_mem[r_t_col];
        end
        if (r_clr_busy) begin
            r_occ_mem[r_clr_cnt] <= '0;
        end else if (en && r_r_v && !r_r_frame) begin
            r_occ_mem[r_r_col] <= {1'b1, new_occ};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_col <= r_r_col;
            r_fwd_val <= new_occ;
        end
    end

    // Clearing pass after reset and at each frame start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
            r_fwd_v    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    r_clr_busy <= 1'b0;
                    r_clr_done <= 1'b1;
                end
            end else if (r_r_v && r_r_frame && !r_clr_done) begin
                r_clr_busy <= 1'b1;
            end else if (en) begin
                r_clr_done <= 1'b0;
            end
            if (r_clr_busy) begin
                r_fwd_v <= 1'b0;
            end else if (en) begin
                r_fwd_v <= r_r_v && !r_r_frame;
            end
        end
    end

    // Span output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_span_valid  <= span_ok;
            o_span_column <= r_r_col;
            o_span_top    <= span_ok ? top_c[11:0] : 12'd0;
            o_span_bottom <= span_ok ? bottom[11:0] : 12'd0;
            o_span_color  <= r_r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_r_v && !r_r_frame;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;

endmodule
`default_nettype wire
